FILE: hdl/chaikin_pkg.sv
// Shared definitions for the Chaikin polyline smoother.
// Holds the cell phase type, parameter defaults and register constants; no dependencies.
package chaikin_pkg;

    localparam int MAX_DEGREE_DEF = 5;
    localparam int COORD_BITS_DEF = 16;

    // Width and reset value of the pass count register.
    localparam int PASS_W = 3;
    localparam logic [PASS_W-1:0] PASS_COUNT_RST = 3'd1;

    // What a cell emits next for the point it holds.
    typedef enum logic [1:0] {
        PH_CUT_A,   // (3*prior + current) / 4
        PH_CUT_B,   // (prior + 3*current) / 4
        PH_CUR      // the current point itself, with its last mark
    } t_phase;

endpackage

FILE: hdl/chaikin_cell.sv
// One corner-cutting pass of the Chaikin smoother, as a cell of the chain.
// Depends on chaikin_pkg for the phase type and parameter defaults.
module chaikin_cell
    import chaikin_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_enable,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  logic                  i_last,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_x,
    output logic [COORD_BITS-1:0] o_y,
    output logic                  o_last
);

    localparam int SW = COORD_BITS + 2;

    // (3a + b) / 4, truncated toward zero. The sum is exact in SW bits.
    function automatic logic [COORD_BITS-1:0] cut(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
        logic signed [SW-1:0] ae;
        logic signed [SW-1:0] be;
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] adj;
        logic signed [SW-1:0] quo;
        ae  = SW'(signed'(a));
        be  = SW'(signed'(b));
        sum = (ae <<< 1) + ae + be;
        adj = sum + {{(SW-2){1'b0}}, sum[SW-1], sum[SW-1]};
        quo = adj >>> 2;
        return quo[COORD_BITS-1:0];
    endfunction

    logic                  r_busy, n_busy;
    t_phase                r_phase, n_phase;
    logic                  r_prior_valid;
    logic [COORD_BITS-1:0] r_prior_x, r_prior_y;
    logic [COORD_BITS-1:0] r_cx, r_cy, r_px, r_py;
    logic                  r_last;
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic                  r_out_last;

    logic                  w_out_free, w_emit, w_finish, w_accept;
    logic [COORD_BITS-1:0] w_sel_x, w_sel_y;
    logic                  w_sel_last;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = r_busy && w_out_free;
    assign w_finish   = w_emit && ((r_phase == PH_CUR) || (r_phase == PH_CUT_B && !r_last));
    assign o_in_stall = r_busy && !w_finish;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Next phase. A new point may be taken in the cycle the previous one finishes.
    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        if (w_accept) begin
            n_busy  = 1'b1;
            n_phase = (i_enable && r_prior_valid) ? PH_CUT_A : PH_CUR;
        end else if (w_finish) begin
            n_busy = 1'b0;
        end else if (w_emit) begin
            unique case (r_phase)
                PH_CUT_A: n_phase = PH_CUT_B;
                PH_CUT_B: n_phase = PH_CUR;
                default:  n_phase = PH_CUR;
            endcase
        end
    end

    // Point emitted in the current phase.
    always_comb begin
        unique case (r_phase)
            PH_CUT_A: begin
                w_sel_x    = cut(r_px, r_cx);
                w_sel_y    = cut(r_py, r_cy);
                w_sel_last = 1'b0;
            end
            PH_CUT_B: begin
                w_sel_x    = cut(r_cx, r_px);
                w_sel_y    = cut(r_cy, r_py);
                w_sel_last = 1'b0;
            end
            default: begin
                w_sel_x    = r_cx;
                w_sel_y    = r_cy;
                w_sel_last = r_last;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_phase       <= PH_CUR;
            r_prior_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            if (w_accept && i_enable) begin
                r_prior_valid <= !i_last;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers. The working copy keeps the old prior so the
    // stored point can be updated at once on acceptance.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cx   <= i_x;
            r_cy   <= i_y;
            r_px   <= r_prior_x;
            r_py   <= r_prior_y;
            r_last <= i_last;
            if (i_enable && !i_last) begin
                r_prior_x <= i_x;
                r_prior_y <= i_y;
            end
        end
        if (w_emit) begin
            r_out_x    <= w_sel_x;
            r_out_y    <= w_sel_y;
            r_out_last <= w_sel_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_x         = r_out_x;
    assign o_y         = r_out_y;
    assign o_last      = r_out_last;

endmodule

FILE: hdl/chaikin_polyline_smoother_unit.sv
// Top level of the Chaikin polyline smoother: pass count register and the chain of cells.
// Depends on chaikin_pkg and chaikin_cell.
//
// The block takes polyline vertices one transaction at a time and returns the
// polyline after pass_count rounds of Chaikin corner cutting. The first vertex
// of a line comes out unchanged; every later vertex yields the two cut points
// (3p+c)/4 and (p+3c)/4, rounded toward zero, and the vertex marked with
// end_of_line is also repeated itself with last_point set. A chain of
// MAX_DEGREE identical cells does the work, one cell per pass; cells beyond
// pass_count simply forward points without touching their stored vertex.
// Each cell emits at most one point per cycle and accepts its next point in
// the cycle it emits the final point of the current one. With k passes an
// interior vertex makes 2^k output transactions; the output side sets the
// rate at one point per cycle while the receiver does not stall. A point
// passes a cell's working and then its output registers. pass_count may only
// be written while the block is idle; values above MAX_DEGREE saturate.

module chaikin_polyline_smoother_unit
    import chaikin_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration: pass count
    input  logic                  i_cfg_we,
    input  logic [PASS_W-1:0]     i_cfg_wdata,
    // Vertex input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_BITS-1:0] i_vertex_x,
    input  logic [COORD_BITS-1:0] i_vertex_y,
    input  logic                  i_end_of_line,
    // Smoothed point output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_point_x,
    output logic [COORD_BITS-1:0] o_point_y,
    output logic                  o_last_point
);

    localparam logic [PASS_W-1:0] MaxPass = PASS_W'(MAX_DEGREE);

    logic [PASS_W-1:0] r_pass_count;

    // Links of the chain: index g feeds cell g, index g+1 is its output.
    logic [MAX_DEGREE:0]                 w_vld;
    logic [MAX_DEGREE:0]                 w_stall;
    logic [MAX_DEGREE:0][COORD_BITS-1:0] w_x;
    logic [MAX_DEGREE:0][COORD_BITS-1:0] w_y;
    logic [MAX_DEGREE:0]                 w_last;
    logic [MAX_DEGREE-1:0]               w_cell_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_count <= PASS_COUNT_RST;
        end else if (i_cfg_we) begin
            r_pass_count <= (i_cfg_wdata > MaxPass) ? MaxPass : i_cfg_wdata;
        end
    end

    assign w_vld[0]   = i_in_valid;
    assign w_x[0]     = i_vertex_x;
    assign w_y[0]     = i_vertex_y;
    assign w_last[0]  = i_end_of_line;
    assign o_in_stall = w_stall[0];

    for (genvar g = 0; g < MAX_DEGREE; g++) begin : g_cell
        // Cell g runs a pass only when the pass count reaches past it.
        assign w_cell_en[g] = (r_pass_count > PASS_W'(g));

        chaikin_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_enable    (w_cell_en[g]),
            .i_in_valid  (w_vld[g]),
            .o_in_stall  (w_stall[g]),
            .i_x         (w_x[g]),
            .i_y         (w_y[g]),
            .i_last      (w_last[g]),
            .o_out_valid (w_vld[g+1]),
            .i_out_stall (w_stall[g+1]),
            .o_x         (w_x[g+1]),
            .o_y         (w_y[g+1]),
            .o_last      (w_last[g+1])
        );
    end

    assign w_stall[MAX_DEGREE] = i_out_stall;
    assign o_out_valid         = w_vld[MAX_DEGREE];
    assign o_point_x           = w_x[MAX_DEGREE];
    assign o_point_y           = w_y[MAX_DEGREE];
    assign o_last_point        = w_last[MAX_DEGREE];

endmodule

FILE: tb/tb.sv
// Testbench for chaikin_polyline_smoother_unit: directed and random polylines, checked point by point.
// Depends on chaikin_pkg and the smoother RTL; holds its own corner-cutting predictor.
`timescale 1ns / 1ps

module tb;
    import chaikin_pkg::*;

    localparam int CW            = COORD_BITS_DEF;
    localparam int HOLD_CYCLES   = 400;      // long receiver hold-off, fills the cell chain
    localparam int SETTLE_CYCLES = 2 * MAX_DEGREE_DEF + 6;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int RANDOM_ITEMS  = 80;

    // Receiver stall patterns.
    typedef enum int {
        RX_FREE,     // never stalls
        RX_LIGHT,    // stalls about a quarter of the cycles
        RX_HEAVY,    // stalls about three quarters of the cycles
        RX_TOGGLE    // alternates stalling and not stalling
    } t_rx_mode;

    // Predicts the smoothed polyline and keeps the points that are still owed by the block.
    class chaikin_checker;
        typedef struct {
            int x;
            int y;
            bit last;
        } pt_t;

        int  passes = PASS_COUNT_RST;
        int  held_x[MAX_DEGREE_DEF];
        int  held_y[MAX_DEGREE_DEF];
        bit  held_ok[MAX_DEGREE_DEF];
        pt_t due_points[$];
        int  faults = 0;

        task mismatch(string msg);
            $display("tb: mismatch: %s", msg);
            faults++;
        endtask

        function void set_passes(int v);
            passes = (v > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : v;
        endfunction

        function int outstanding();
            return due_points.size();
        endfunction

        // Runs one vertex through the active stages. Stages beyond the pass count
        // are left alone, so their stored vertex survives a pass count change.
        function void take_vertex(logic [CW-1:0] vx, logic [CW-1:0] vy, logic eol);
            pt_t flow[$];
            pt_t nxt[$];
            pt_t c;
            pt_t p;
            c.x = $signed(vx);
            c.y = $signed(vy);
            c.last = eol;
            flow = {c};
            for (int s = 0; s < passes; s++) begin
                nxt.delete();
                foreach (flow[i]) begin
                    c = flow[i];
                    if (!held_ok[s]) begin
                        // First point of a line in this stage goes through as it is.
                        nxt = {nxt, c};
                        if (!c.last) begin
                            held_x[s] = c.x;
                            held_y[s] = c.y;
                            held_ok[s] = 1'b1;
                        end
                    end else begin
                        p.last = 1'b0;
                        p.x = (3 * held_x[s] + c.x) / 4;
                        p.y = (3 * held_y[s] + c.y) / 4;
                        nxt = {nxt, p};
                        p.x = (held_x[s] + 3 * c.x) / 4;
                        p.y = (held_y[s] + 3 * c.y) / 4;
                        nxt = {nxt, p};
                        if (c.last) begin
                            nxt = {nxt, c};
                            held_ok[s] = 1'b0;
                        end else begin
                            held_x[s] = c.x;
                            held_y[s] = c.y;
                        end
                    end
                end
                flow = nxt;
            end
            due_points = {due_points, flow};
        endfunction

        task check_point(logic [CW-1:0] gx, logic [CW-1:0] gy, logic gl);
            pt_t e;
            logic [CW-1:0] ex;
            logic [CW-1:0] ey;
            if (due_points.size() == 0) begin
                mismatch($sformatf("unexpected point (%0d, %0d) last=%0b",
                                   $signed(gx), $signed(gy), gl));
                return;
            end
            e = due_points.pop_front();
            ex = e.x[CW-1:0];
            ey = e.y[CW-1:0];
            if (gx !== ex)
                mismatch($sformatf("point_x %0d, expected %0d", $signed(gx), $signed(ex)));
            if (gy !== ey)
                mismatch($sformatf("point_y %0d, expected %0d", $signed(gy), $signed(ey)));
            if (gl !== e.last)
                mismatch($sformatf("last_point %0b, expected %0b", gl, e.last));
        endtask

        task close();
            if (due_points.size() != 0)
                mismatch($sformatf("%0d points never arrived", due_points.size()));
        endtask
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [PASS_W-1:0] i_cfg_wdata;
    logic          i_in_valid;
    logic          o_in_stall;
    logic [CW-1:0] i_vertex_x;
    logic [CW-1:0] i_vertex_y;
    logic          i_end_of_line;
    logic          o_out_valid;
    logic          i_out_stall;
    logic [CW-1:0] o_point_x;
    logic [CW-1:0] o_point_y;
    logic          o_last_point;

    chaikin_checker board = new();

    // Sender burst state. While steady is set the sender offers back to back.
    int burst_left = 0;
    bit steady = 1'b0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_req = 1'b0;

    chaikin_polyline_smoother_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_vertex_x   (i_vertex_x),
        .i_vertex_y   (i_vertex_y),
        .i_end_of_line(i_end_of_line),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y),
        .o_last_point (o_last_point)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run. The slowest correct run (every vertex making its
    // full cascade of points against a heavily stalling receiver) stays well
    // below this.
    initial begin
        #5000000;
        $display("tb: done, errors");
        $finish;
    end

    // Output side. Every rising edge first looks at the transaction that the
    // edge completes, using the values from before the edge, and then picks
    // the stall for the next cycle. The pattern changes on its own schedule,
    // independent of the sender, so stalls land on every phase of a cell's
    // cut-cut-current sequence.
    initial begin
        t_rx_mode mode;
        int mode_left;
        int hold_left;
        mode = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                board.check_point(o_point_x, o_point_y, o_last_point);
            if (mode_left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(1, 60);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                // Long hold-off: the cells fill and the input stall must rise.
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    RX_FREE:   i_out_stall <= 1'b0;
                    RX_LIGHT:  i_out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:  i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:   i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    // Offers one vertex and holds it until the block takes it. The expected
    // points are computed at the accepting edge. Outside steady stretches the
    // sender then may drop valid for a random gap at the end of a burst.
    task automatic offer_vertex(input logic [CW-1:0] vx, input logic [CW-1:0] vy,
                                input logic eol);
        int gap;
        i_in_valid    <= 1'b1;
        i_vertex_x    <= vx;
        i_vertex_y    <= vy;
        i_end_of_line <= eol;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.take_vertex(vx, vy, eol);
        if (!steady) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 6);
                burst_left = $urandom_range(0, 8);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stops offering and waits until every expected point has come out, then
    // lets the cell chain settle before anything is reconfigured.
    task automatic drain_points();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (board.outstanding() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the pass count; only called with the block idle.
    task automatic write_passes(input int v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= PASS_W'(v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_passes(v);
    endtask

    // Mostly full-range coordinates, with small values to exercise rounding
    // toward zero around the origin and the two's complement extremes.
    function automatic logic [CW-1:0] pick_coord();
        case ($urandom_range(0, 19))
            0:       return {1'b1, {(CW-1){1'b0}}};
            1:       return {1'b0, {(CW-1){1'b1}}};
            2:       return '1;
            3:       return '0;
            4, 5, 6: return CW'($urandom_range(0, 16) - 8);
            default: return CW'($urandom());
        endcase
    endfunction

    initial begin
        int done_items;
        int n;
        bit held_off;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        i_in_valid    <= 1'b0;
        i_vertex_x    <= '0;
        i_vertex_y    <= '0;
        i_end_of_line <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Reset pass count of one: extremes, rounding of
        // negative cuts, then a polyline of a single vertex.
        offer_vertex(16'sh8000, 16'sh7fff, 1'b0);
        offer_vertex(16'sh7fff, 16'sh8000, 1'b0);
        offer_vertex(-16'sd1, -16'sd3, 1'b0);
        offer_vertex(16'sd5, -16'sd7, 1'b1);
        offer_vertex(16'sh8000, 16'sh8000, 1'b1);
        drain_points();

        // Zero passes: everything goes straight through, marks included.
        write_passes(0);
        offer_vertex(16'sd100, -16'sd100, 1'b0);
        offer_vertex(16'sh7fff, 16'sh7fff, 1'b1);
        offer_vertex(-16'sd5, 16'sd3, 1'b1);
        drain_points();

        // Full depth: the closing vertex of a line makes the largest burst.
        write_passes(MAX_DEGREE_DEF);
        offer_vertex(16'sh8000, 16'sh7fff, 1'b0);
        offer_vertex(16'sh7fff, 16'sh8000, 1'b1);
        offer_vertex(16'sd7, -16'sd9, 1'b1);
        drain_points();

        // A value above the maximum saturates.
        write_passes(7);
        offer_vertex(16'sd1, 16'sd2, 1'b0);
        offer_vertex(-16'sd3, -16'sd3, 1'b0);
        offer_vertex(16'sd0, 16'sd0, 1'b1);
        drain_points();

        // Pass count changed in the middle of a line: the dropped stage keeps
        // its stored vertex and picks it up again when the count grows.
        write_passes(2);
        offer_vertex(16'sd10, 16'sd20, 1'b0);
        offer_vertex(-16'sd30, 16'sd40, 1'b0);
        drain_points();
        write_passes(1);
        offer_vertex(16'sd50, -16'sd60, 1'b0);
        offer_vertex(16'sd70, 16'sd80, 1'b1);
        drain_points();
        write_passes(3);
        offer_vertex(-16'sd11, 16'sd13, 1'b0);
        offer_vertex(16'sd15, -16'sd17, 1'b1);
        drain_points();
        write_passes(4);
        offer_vertex(16'sd3, 16'sd3, 1'b1);
        drain_points();
        write_passes(6);
        offer_vertex(-16'sd2, 16'sd1, 1'b1);
        drain_points();

        // Random part. Lines run across phase boundaries, so a pass count
        // change often falls in the middle of a line. The first phase holds
        // the receiver off while the sender keeps offering back to back.
        done_items = 0;
        held_off = 1'b0;
        while (done_items < RANDOM_ITEMS) begin
            if (!held_off) begin
                write_passes(3);
                n = 24;
                steady = 1'b1;
                hold_req = 1'b1;
                held_off = 1'b1;
            end else begin
                write_passes(($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 3));
                n = $urandom_range(6, 16);
            end
            repeat (n) begin
                offer_vertex(pick_coord(), pick_coord(), $urandom_range(0, 4) == 0);
                done_items++;
            end
            steady = 1'b0;
            drain_points();
        end

        board.close();
        if (board.faults == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
